/* sv/mba_pkg.sv */
// Package for the per-symbol minute bar aggregator.
// Holds the word types, opcodes, state codes and sizing constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mba_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int QUEUE_DEPTH       = 2;

    // Message opcodes as they arrive on the input channel.
    typedef enum logic [1:0] {
        OP_TRADE = 2'd0,
        OP_QUOTE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Sequencer states of the table engine.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] symbol;
        logic [15:0] minute;
        logic [31:0] price;
        logic [31:0] trade_volume;
        logic [31:0] bid_qty;
        logic [31:0] offer_qty;
    } t_in_word;

    typedef struct packed {
        logic [63:0] bar_symbol;
        logic [15:0] bar_minute;
        logic [31:0] open_px;
        logic [31:0] high_px;
        logic [31:0] low_px;
        logic [31:0] close_px;
        logic [47:0] total_volume;
        logic [47:0] bid_total;
        logic [47:0] ask_total;
        logic        table_full;
        logic        last;
    } t_out_word;

    // Classified command passed from the front to the back.
    typedef struct packed {
        t_op         op;
        logic [63:0] symbol;
        logic [15:0] minute;
        logic [31:0] price;
        logic [31:0] tvol;
        logic [31:0] bid;
        logic [31:0] ask;
    } t_cmd;

    // One bar as held in the table.
    typedef struct packed {
        logic [63:0] symbol;
        logic [15:0] minute;
        logic [31:0] open;
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] close;
        logic [47:0] volume;
        logic [47:0] bid;
        logic [47:0] ask;
    } t_bar;

    // Saturating 48-bit total plus a 32-bit increment.
    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

endpackage
`default_nettype wire

/* sv/mba_front.sv */
// Front of the bar aggregator: accepts input words, classifies them and queues commands.
// Depends on mba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mba_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  mba_pkg::t_in_word     i_word,
    output logic                  o_stall,
    output logic                  o_cmd_valid,
    output mba_pkg::t_cmd         o_cmd,
    input  wire                   i_cmd_pop
);
    import mba_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          accept, push, pop;
    t_cmd          cmd;

    // Turn the raw word into a command; OP_NONE words are accepted but never queued.
    always_comb begin
        cmd.op     = t_op'(i_word.opcode);
        cmd.symbol = i_word.symbol;
        cmd.minute = i_word.minute;
        cmd.price  = i_word.price;
        cmd.tvol   = i_word.trade_volume;
        cmd.bid    = i_word.bid_qty;
        cmd.ask    = i_word.offer_qty;
    end

    assign o_stall     = (r_cnt == CW'(QUEUE_DEPTH));
    assign accept      = i_valid && !o_stall;
    assign push        = accept && (cmd.op != OP_NONE);
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

endmodule
`default_nettype wire

/* sv/mba_back.sv */
// Back of the bar aggregator: symbol match, read-modify-write of the bar table,
// flush walk and the output word register. Depends on mba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mba_back #(
    parameter int TABLE_ENTRIES = mba_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cmd_valid,
    input  mba_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_valid,
    output mba_pkg::t_out_word    o_word,
    input  wire                   i_stall
);
    import mba_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RW = $clog2(MAX_RESULTS);

    t_state                   r_state, n_state;
    t_cmd                     r_cmd;
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_bar                     r_tab [TABLE_ENTRIES];
    logic                     r_hit, r_free;
    logic [IW-1:0]            r_hit_idx, r_free_idx, r_idx;
    logic [RW-1:0]            r_cnt;
    logic                     r_out_valid;
    t_out_word                r_out;

    logic                     hit, free;
    logic [IW-1:0]            hit_idx, free_idx;
    logic                     slot_free, emit, wr_en, clr_en, done;
    logic [IW-1:0]            wr_idx;
    t_bar                     wr_bar, rd, fresh;
    t_out_word                res;
    logic                     newer, same, valid_above, flush_last, walk_end;

    // Symbol match and free-entry search, lowest index first.
    always_comb begin
        hit = 1'b0; free = 1'b0; hit_idx = '0; free_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r_valid[i] && r_tab[i].symbol == r_cmd.symbol && !hit) begin
                hit = 1'b1; hit_idx = IW'(i);
            end
            if (!r_valid[i] && !free) begin
                free = 1'b1; free_idx = IW'(i);
            end
        end
    end

    // Entry read and the flush walk's look ahead.
    always_comb begin
        valid_above = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (IW'(i) > r_idx && r_valid[i]) valid_above = 1'b1;
        end
    end
    assign rd         = (r_state == S_FLUSH) ? r_tab[r_idx] : r_tab[r_hit_idx];
    assign newer      = r_cmd.minute > rd.minute;
    assign same       = r_cmd.minute == rd.minute;
    assign flush_last = !valid_above || (r_cnt == RW'(MAX_RESULTS - 1));
    assign walk_end   = r_idx == IW'(TABLE_ENTRIES - 1);
    assign slot_free  = !r_out_valid || !i_stall;

    // Fresh bar started by a trade or a quote.
    always_comb begin
        fresh.symbol = r_cmd.symbol;
        fresh.minute = r_cmd.minute;
        fresh.open   = (r_cmd.op == OP_TRADE) ? r_cmd.price : '0;
        fresh.high   = fresh.open;
        fresh.low    = fresh.open;
        fresh.close  = fresh.open;
        fresh.volume = (r_cmd.op == OP_TRADE) ? {16'd0, r_cmd.tvol} : '0;
        fresh.bid    = (r_cmd.op == OP_TRADE) ? '0 : {16'd0, r_cmd.bid};
        fresh.ask    = (r_cmd.op == OP_TRADE) ? '0 : {16'd0, r_cmd.ask};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.op == OP_FLUSH) ? S_FLUSH : S_MATCH;
                end
            end
            S_MATCH: n_state = S_EXEC;
            S_EXEC: begin
                if (done) n_state = S_IDLE;
            end
            S_FLUSH: begin
                if (done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Actions of each state.
    always_comb begin
        o_cmd_pop = 1'b0;
        emit = 1'b0; wr_en = 1'b0; clr_en = 1'b0; done = 1'b0;
        wr_idx = r_hit_idx; wr_bar = rd;
        res = '0;
        unique case (r_state)
            S_IDLE: o_cmd_pop = i_cmd_valid;
            S_MATCH: ;
            S_EXEC: begin
                if (!r_hit && !r_free) begin
                    // Unknown symbol and no room: report a dropped message.
                    res.bar_symbol = r_cmd.symbol;
                    res.bar_minute = r_cmd.minute;
                    res.table_full = 1'b1;
                    res.last       = 1'b1;
                    emit = slot_free;
                    done = slot_free;
                end else if (!r_hit) begin
                    wr_en = 1'b1; wr_idx = r_free_idx; wr_bar = fresh; done = 1'b1;
                end else if (newer) begin
                    res = {rd.symbol, rd.minute, rd.open, rd.high, rd.low, rd.close,
                           rd.volume, rd.bid, rd.ask, 1'b0, 1'b1};
                    emit  = slot_free;
                    wr_en = slot_free;
                    wr_bar = fresh;
                    done  = slot_free;
                end else if (same) begin
                    wr_en = 1'b1; done = 1'b1;
                    if (r_cmd.op == OP_TRADE) begin
                        if (r_cmd.price > rd.high) wr_bar.high = r_cmd.price;
                        if (r_cmd.price < rd.low)  wr_bar.low  = r_cmd.price;
                        wr_bar.close  = r_cmd.price;
                        wr_bar.volume = sat_add48(rd.volume, r_cmd.tvol);
                    end else begin
                        wr_bar.bid = sat_add48(rd.bid, r_cmd.bid);
                        wr_bar.ask = sat_add48(rd.ask, r_cmd.ask);
                    end
                end else begin
                    done = 1'b1;
                end
            end
            S_FLUSH: begin
                res = {rd.symbol, rd.minute, rd.open, rd.high, rd.low, rd.close,
                       rd.volume, rd.bid, rd.ask, 1'b0, flush_last};
                if (r_valid[r_idx]) begin
                    emit   = slot_free;
                    clr_en = slot_free;
                    done   = slot_free && (flush_last || walk_end);
                end else begin
                    done = walk_end;
                end
            end
            default: ;
        endcase
    end

    // Table contents.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tab[wr_idx] <= wr_bar;
        end
    end

    // Control state, valid bits and walk counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en)  r_valid[wr_idx] <= 1'b1;
            if (clr_en) r_valid[r_idx]  <= 1'b0;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_idx <= '0;
                r_cnt <= '0;
            end else if (r_state == S_FLUSH && !done) begin
                if (!r_valid[r_idx] || slot_free) r_idx <= r_idx + 1'b1;
                if (emit) r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Command and match registers, and the output word.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (r_state == S_MATCH) begin
            r_hit <= hit; r_hit_idx <= hit_idx;
            r_free <= free; r_free_idx <= free_idx;
        end
        if (emit) r_out <= res;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // A dropped message is always the only result of its input.
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.table_full |-> o_word.last)
        else $error("table_full word without last");

    // The walk only runs for a flush command.
    a_flush_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FLUSH |-> r_cmd.op == OP_FLUSH)
        else $error("flush walk without flush command");

    // A command is taken only when the engine is idle.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_state == S_MATCH || r_state == S_FLUSH)
        else $error("command taken outside idle");

    // Entries are written only from the execute step.
    a_wr_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state == S_EXEC)
        else $error("table written outside execute");

endmodule
`default_nettype wire

/* sv/per_symbol_minute_bar_aggregator_unit.sv */
// Top level of the per-symbol minute bar aggregator.
// Joins mba_front and mba_back; depends on mba_pkg.
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_word  (t_in_word)
// output    out        o_valid / i_stall    o_word  (t_out_word)
//
// A trade or quote goes through pickup from the queue, symbol match, then one
// read-modify-write of the matched table entry; a bar it emits passes the queue,
// the command and match registers and then the output register.
// A flush is picked up and then walks the table one entry per cycle while the
// output is not stalled, ending at the last valid entry or the MAX_RESULTS-th bar.
// Reset clears all valid bits at once; there is no clearing pass.
// A stalled output holds the engine while the two-word queue keeps taking input.
`timescale 1ns / 1ps
`default_nettype none
module per_symbol_minute_bar_aggregator_unit #(
    parameter int TABLE_ENTRIES = mba_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  mba_pkg::t_in_word     i_word,
    output logic                  o_stall,
    output logic                  o_valid,
    output mba_pkg::t_out_word    o_word,
    input  wire                   i_stall
);
    import mba_pkg::*;

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    // Accept and classify.
    mba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_word      (i_word),
        .o_stall     (o_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Table engine.
    mba_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_stall     (i_stall)
    );

endmodule
`default_nettype wire
